/* src/raw_profile_hex_decoder_core_macros.svh */
// Assertion helpers for the hex profile decoder.
`ifndef RAW_PROFILE_HEX_DECODER_CORE_MACROS_SVH
`define RAW_PROFILE_HEX_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define HPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hex profile decoder: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define HPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hex profile decoder: next-cycle check failed");

`endif

/* src/hpd_pkg.sv */
package hpd_pkg;

	// Width of the declared length and of the byte counter
	localparam int LENGTH_BITS = 24;

	// Result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;
	localparam int CNT_W = FIFO_AW + 1;

	// Result kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_NO_LEAD = 2'd0;
	localparam logic [1:0] ERR_NO_NAME_END = 2'd1;
	localparam logic [1:0] ERR_NO_LEN_END = 2'd2;
	localparam logic [1:0] ERR_BAD_LEN = 2'd3;

	// Characters
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_NAME,
		PH_LEN_PRE,
		PH_LEN_NUM,
		PH_DATA,
		PH_DONE
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic [LENGTH_BITS-1:0] declared_length;
		logic has_digit;
		logic digits_closed;
		logic [LENGTH_BITS-1:0] bytes_emitted;
		logic [3:0] high_nibble;
		logic nibble_held;
	} dec_state_t;

	localparam dec_state_t STATE_RESET = '{
		phase: PH_LEAD,
		declared_length: '0,
		has_digit: 1'b0,
		digits_closed: 1'b0,
		bytes_emitted: '0,
		high_nibble: 4'd0,
		nibble_held: 1'b0
	};

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic complete;
		logic [1:0] error_code;
		logic last;
	} res_t;

	// Results raised by one character: count 0..2, first in r0
	typedef struct packed {
		logic [1:0] cnt;
		res_t r0;
		res_t r1;
	} push_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
			(c == CH_FF) || (c == CH_CR);
	endfunction

	// Hex decode: bit 4 flags a hex digit, bits 3:0 its value
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if ((c >= CH_0) && (c <= CH_9)) begin
			d = c - CH_0;
			return {1'b1, d[3:0]};
		end else if ((c >= CH_LA) && (c <= CH_LF_HEX)) begin
			d = c - CH_LA + 8'd10;
			return {1'b1, d[3:0]};
		end else if ((c >= CH_UA) && (c <= CH_UF)) begin
			d = c - CH_UA + 8'd10;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

endpackage

/* src/hpd_step.sv */
module hpd_step (
	input hpd_pkg::dec_state_t st,
	input logic [7:0] char_code,
	input logic end_of_text,
	output hpd_pkg::dec_state_t nxt,
	output hpd_pkg::push_t push
);
	import hpd_pkg::*;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	phase_t phase_mid;
	logic [4:0] hex;
	logic [LENGTH_BITS-1:0] bytes_inc;
	logic [LENGTH_BITS+3:0] len_x10;
	logic [LENGTH_BITS-1:0] len_digit;
	logic [7:0] digit_val;
	phase_t line_end_phase;

	assign hex = hex_nibble(char_code);
	assign bytes_inc = LENGTH_BITS'(st.bytes_emitted + 1'b1);
	assign digit_val = char_code - CH_0;

	// Append one decimal digit, saturating at the maximum length
	assign len_x10 = {1'b0, st.declared_length, 3'b000} + {3'b000, st.declared_length, 1'b0}
		+ {{(LENGTH_BITS){1'b0}}, digit_val[3:0]};
	assign len_digit = (len_x10 > {4'd0, LEN_MAX}) ? LEN_MAX : len_x10[LENGTH_BITS-1:0];

	// Where the length line's newline leads
	assign line_end_phase = (!st.has_digit || (st.declared_length == '0)) ? PH_DONE : PH_DATA;

	// Next state
	always_comb begin
		nxt = st;
		case (st.phase)
			PH_LEAD: begin
				nxt.phase = (char_code == CH_LF) ? PH_NAME : PH_DONE;
			end
			PH_NAME: begin
				if (char_code == CH_LF) nxt.phase = PH_LEN_PRE;
			end
			PH_LEN_PRE: begin
				if (char_code == CH_LF) begin
					nxt.phase = line_end_phase;
				end else if (is_blank(char_code)) begin
					nxt.phase = PH_LEN_PRE;
				end else if (char_code == CH_PLUS) begin
					nxt.phase = PH_LEN_NUM;
				end else if (is_digit(char_code)) begin
					nxt.declared_length = len_digit;
					nxt.has_digit = 1'b1;
					nxt.phase = PH_LEN_NUM;
				end else begin
					nxt.digits_closed = 1'b1;
					nxt.phase = PH_LEN_NUM;
				end
			end
			PH_LEN_NUM: begin
				if (char_code == CH_LF) begin
					nxt.phase = line_end_phase;
				end else if (is_digit(char_code) && !st.digits_closed) begin
					nxt.declared_length = len_digit;
					nxt.has_digit = 1'b1;
				end else begin
					nxt.digits_closed = 1'b1;
				end
			end
			PH_DATA: begin
				if (hex[4]) begin
					if (!st.nibble_held) begin
						nxt.high_nibble = hex[3:0];
						nxt.nibble_held = 1'b1;
					end else begin
						nxt.high_nibble = 4'd0;
						nxt.nibble_held = 1'b0;
						nxt.bytes_emitted = bytes_inc;
						if (bytes_inc >= st.declared_length) nxt.phase = PH_DONE;
					end
				end
			end
			default: begin
				nxt.phase = st.phase;
			end
		endcase
		phase_mid = nxt.phase;
		// Start over after the final character
		if (end_of_text) nxt = STATE_RESET;
	end

	// Results: those of the character first, then the end-of-text one
	always_comb begin
		res_t r [2];
		logic [1:0] cnt;
		res_t end_res;
		r[0] = '0;
		r[1] = '0;
		cnt = 2'd0;
		end_res = '0;
		case (st.phase)
			PH_LEAD: begin
				if (char_code != CH_LF) begin
					r[cnt[0]] = '{kind: KIND_ERROR, data_byte: 8'd0, complete: 1'b0,
						error_code: ERR_NO_LEAD, last: 1'b1};
					cnt = cnt + 2'd1;
				end
			end
			PH_LEN_PRE, PH_LEN_NUM: begin
				if (char_code == CH_LF) begin
					if (!st.has_digit) begin
						r[cnt[0]] = '{kind: KIND_ERROR, data_byte: 8'd0, complete: 1'b0,
							error_code: ERR_BAD_LEN, last: 1'b1};
						cnt = cnt + 2'd1;
					end else if (st.declared_length == '0) begin
						r[cnt[0]] = '{kind: KIND_END, data_byte: 8'd0, complete: 1'b1,
							error_code: ERR_NO_LEAD, last: 1'b1};
						cnt = cnt + 2'd1;
					end
				end
			end
			PH_DATA: begin
				if (hex[4] && st.nibble_held) begin
					r[cnt[0]] = '{kind: KIND_DATA, data_byte: {st.high_nibble, hex[3:0]},
						complete: 1'b0, error_code: ERR_NO_LEAD, last: 1'b0};
					cnt = cnt + 2'd1;
					if (bytes_inc >= st.declared_length) begin
						r[cnt[0]] = '{kind: KIND_END, data_byte: 8'd0, complete: 1'b1,
							error_code: ERR_NO_LEAD, last: 1'b1};
						cnt = cnt + 2'd1;
					end
				end
			end
			default: begin
				cnt = 2'd0;
			end
		endcase
		if (end_of_text) begin
			case (phase_mid)
				PH_NAME: begin
					end_res = '{kind: KIND_ERROR, data_byte: 8'd0, complete: 1'b0,
						error_code: ERR_NO_NAME_END, last: 1'b1};
					r[cnt[0]] = end_res;
					cnt = cnt + 2'd1;
				end
				PH_LEN_PRE, PH_LEN_NUM: begin
					end_res = '{kind: KIND_ERROR, data_byte: 8'd0, complete: 1'b0,
						error_code: ERR_NO_LEN_END, last: 1'b1};
					r[cnt[0]] = end_res;
					cnt = cnt + 2'd1;
				end
				PH_DATA: begin
					end_res = '{kind: KIND_END, data_byte: 8'd0, complete: 1'b0,
						error_code: ERR_NO_LEAD, last: 1'b1};
					r[cnt[0]] = end_res;
					cnt = cnt + 2'd1;
				end
				default: begin
					end_res = '0;
				end
			endcase
		end
		push.cnt = cnt;
		push.r0 = r[0];
		push.r1 = r[1];
	end

endmodule

/* src/hpd_res_fifo.sv */
module hpd_res_fifo (
	input logic clk,
	input logic arst_n,
	input hpd_pkg::push_t push,
	input logic pop,
	output logic room,
	output logic out_valid,
	output hpd_pkg::res_t out_res
);
	import hpd_pkg::*;

	res_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic [FIFO_AW-1:0] wr_next1;

	assign wr_next1 = FIFO_AW'(wr_q + 1'b1);

	// Store up to two results a cycle
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) mem_q[wr_q] <= push.r0;
		if (push.cnt == 2'd2) mem_q[wr_next1] <= push.r1;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= FIFO_AW'(wr_q + push.cnt);
			if (pop) rd_q <= FIFO_AW'(rd_q + 1'b1);
			count_q <= CNT_W'(count_q + CNT_W'(push.cnt) - CNT_W'(pop));
		end
	end

	// Room for the worst case of two results
	assign room = count_q <= CNT_W'(FIFO_DEPTH - 2);
	assign out_valid = count_q != '0;
	assign out_res = mem_q[rd_q];

endmodule

/* src/raw_profile_hex_decoder_core.sv */
// Channel   Dir  tdata                                       tuser      tlast
// s_axis    in   [7:0] char_code                             -          end_of_text
// m_axis    out  [7:0] data_byte, [8] complete,              [1:0] kind last
//                [10:9] error_code, [15:11] zero
//
// One character is taken per cycle; the step logic sits between the input
// register and a four-word result queue.
// A character yields at most two words (a final byte with its end marker, or
// a byte with the short end marker); the output offers them one at a time.
// Input stalls only while the queue holds more than two words.
// arst_n clears the queue and puts the parser back to expecting the newline.
// A taken character waits in the input register until the queue has room;
// then its words are written into the queue, and its first word is offered
// once the words ahead of it have left.
`include "raw_profile_hex_decoder_core_macros.svh"

module raw_profile_hex_decoder_core (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata, // [7:0] char_code
	input logic s_axis_tlast,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [15:0] m_axis_tdata, // [7:0] data_byte, [8] complete, [10:9] error_code
	output logic [1:0] m_axis_tuser, // [1:0] kind
	output logic m_axis_tlast
);
	import hpd_pkg::*;

	logic valid_s1;
	logic [7:0] char_s1;
	logic eot_s1;
	logic adv;
	logic room;
	dec_state_t state_q;
	dec_state_t state_next;
	push_t step_push;
	push_t fifo_push;
	res_t out_res;

	// Step the character in the input register when the queue has room
	assign adv = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			eot_s1 <= s_axis_tlast;
		end
	end

	hpd_step u_step (
		.st(state_q),
		.char_code(char_s1),
		.end_of_text(eot_s1),
		.nxt(state_next),
		.push(step_push)
	);

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (adv) begin
			state_q <= state_next;
		end
	end

	// Drop the results unless the character is stepped
	always_comb begin
		fifo_push = step_push;
		if (!adv) fifo_push.cnt = 2'd0;
	end

	hpd_res_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(fifo_push),
		.pop(m_axis_tvalid && m_axis_tready),
		.room(room),
		.out_valid(m_axis_tvalid),
		.out_res(out_res)
	);

	// Pack the output word
	assign m_axis_tdata = {5'd0, out_res.error_code, out_res.complete, out_res.data_byte};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last;

	`HPD_ASSERT_NXT(a_eot_restarts, clk, arst_n, adv && eot_s1, state_q.phase == PH_LEAD)
	`HPD_ASSERT_IMP(a_done_silent, clk, arst_n, valid_s1 && (state_q.phase == PH_DONE), step_push.cnt == 2'd0)
	`HPD_ASSERT_IMP(a_second_is_last, clk, arst_n, step_push.cnt == 2'd2, step_push.r1.last && !step_push.r0.last)

endmodule
